// File: rtl/plbs_pkg.sv
// Package for the PHY link bring-up sequencer: payload types, codes and bit masks.
package plbs_pkg;

  typedef struct packed {
    logic [1:0]  operation;
    logic        force_reset;
    logic        refresh;
    logic        transfer_ok;
    logic [15:0] read_value;
  } plbs_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  phy_number;
    logic [4:0]  register_number;
    logic [15:0] write_value;
    logic [1:0]  init_status;
    logic [4:0]  link_flags;
  } plbs_out_t;

  // Input operations
  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_XFER  = 2'd2;
  localparam logic [1:0] OP_DELAY = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_READ  = 3'd0;
  localparam logic [2:0] KIND_WRITE = 3'd1;
  localparam logic [2:0] KIND_DELAY = 3'd2;
  localparam logic [2:0] KIND_INIT  = 3'd3;
  localparam logic [2:0] KIND_LINK  = 3'd4;

  // Init status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BUSY = 2'd1;
  localparam logic [1:0] STAT_HWER = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PHY_ADDR  = 2'd0;
  localparam logic [1:0] CFG_RST_LIMIT = 2'd1;
  localparam logic [1:0] CFG_AN_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_LU_LIMIT  = 2'd3;

  // MII registers
  localparam logic [4:0] REG_CTRL = 5'd0;
  localparam logic [4:0] REG_STAT = 5'd1;
  localparam logic [4:0] REG_ADV  = 5'd4;
  localparam logic [4:0] REG_LP   = 5'd5;

  // Sequencer steps
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RST_WR  = 4'd1;
  localparam logic [3:0] ST_RST_RD  = 4'd2;
  localparam logic [3:0] ST_RST_DLY = 4'd3;
  localparam logic [3:0] ST_AN_RD   = 4'd4;
  localparam logic [3:0] ST_AN_DLY  = 4'd5;
  localparam logic [3:0] ST_CTL_RD  = 4'd6;
  localparam logic [3:0] ST_FRC_WR  = 4'd7;
  localparam logic [3:0] ST_LUF_RD  = 4'd8;
  localparam logic [3:0] ST_LUF_DLY = 4'd9;
  localparam logic [3:0] ST_LUA_RD  = 4'd10;
  localparam logic [3:0] ST_LUA_DLY = 4'd11;
  localparam logic [3:0] ST_UPD_ADV = 4'd12;
  localparam logic [3:0] ST_UPD_LP  = 4'd13;
  localparam logic [3:0] ST_UPD_ST  = 4'd14;

  // Register bits
  localparam logic [15:0] CTL_RESET    = 16'h8000;
  localparam logic [15:0] CTL_SPEED100 = 16'h2000;
  localparam logic [15:0] CTL_AN_RST   = 16'h0200;
  localparam logic [15:0] CTL_FULL     = 16'h0040;
  localparam logic [15:0] STA_100_MASK = 16'hA200;
  localparam logic [15:0] STA_10       = 16'h0800;
  localparam logic [15:0] STA_AN_DONE  = 16'h0020;
  localparam logic [15:0] STA_LINK     = 16'h0004;
  localparam logic [15:0] ADV_100      = 16'h0180;
  localparam logic [15:0] ADV_10       = 16'h0060;
  localparam logic [15:0] ADV_FULL     = 16'h0140;
  localparam logic [15:0] ADV_HALF     = 16'h00A0;

  // Link flags
  localparam logic [4:0] LNK_ACTIVE = 5'h01;
  localparam logic [4:0] LNK_100    = 5'h02;
  localparam logic [4:0] LNK_10     = 5'h04;
  localparam logic [4:0] LNK_FULL   = 5'h08;
  localparam logic [4:0] LNK_HALF   = 5'h10;

endpackage

// File: rtl/phy_link_bringup_sequencer.sv
// PHY link bring-up sequencer: event-driven MII reset, autoneg and link resolution.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid, in_stall, in_data      | event in
//   out     | out_valid, out_stall, out_data   | request/reply out
//   cfg     | cfg_write, cfg_index, cfg_data   | register write in
//
// Each event is held in the input register and is resolved into the result register
// unless the result is stalled; one event per cycle is sustained while it is not stalled.
// The result is registered: it passes the input register and then the result register.
// rst is synchronous; it clears the sequencer and the cache and loads the config defaults.
// Events that produce no result still take a slot; a stalled result holds
// the input register, which then stalls the input.
module phy_link_bringup_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  plbs_pkg::plbs_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output plbs_pkg::plbs_out_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  // configuration
  logic [4:0]  phy_address;
  logic [15:0] reset_poll_limit;
  logic [15:0] autoneg_poll_limit;
  logic [15:0] linkup_poll_limit;

  // input register
  logic               item_valid;
  plbs_pkg::plbs_in_t item;

  // sequencer state
  logic [3:0]  step, step_next;
  logic [15:0] poll_count, poll_count_next;
  logic        initialized, initialized_next;
  logic [4:0]  cached_link, cached_link_next;
  logic [15:0] control_copy, control_copy_next;
  logic [15:0] status_copy, status_copy_next;
  logic [15:0] advert_copy, advert_copy_next;
  logic        serving_query, serving_query_next;

  // result of this event
  logic        res_fire;
  logic [2:0]  res_kind;
  logic [4:0]  res_reg;
  logic [15:0] res_wval;
  logic [1:0]  res_st;
  logic [4:0]  res_flags;
  plbs_pkg::plbs_out_t res;

  logic proc;
  logic go_autoneg, go_linkup, go_end_linkup, go_update, go_end_update;
  logic forced, upd_ok;
  logic [16:0] poll_inc;
  logic [4:0]  st_flags;
  logic [15:0] shared;

  assign proc     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !proc;
  assign poll_inc = {1'b0, poll_count} + 17'd1;

  always_comb begin
    step_next          = step;
    poll_count_next    = poll_count;
    initialized_next   = initialized;
    cached_link_next   = cached_link;
    control_copy_next  = control_copy;
    status_copy_next   = status_copy;
    advert_copy_next   = advert_copy;
    serving_query_next = serving_query;
    res_fire      = 1'b0;
    res_kind      = plbs_pkg::KIND_READ;
    res_reg       = plbs_pkg::REG_CTRL;
    res_wval      = 16'h0000;
    res_st        = plbs_pkg::STAT_OK;
    res_flags     = 5'h00;
    go_autoneg    = 1'b0;
    go_linkup     = 1'b0;
    go_end_linkup = 1'b0;
    go_update     = 1'b0;
    go_end_update = 1'b0;
    forced        = 1'b0;
    upd_ok        = 1'b0;
    st_flags      = 5'h00;
    shared        = 16'h0000;

    case (item.operation)
      plbs_pkg::OP_INIT: begin
        if (step != plbs_pkg::ST_IDLE) begin
          res_fire = 1'b1;
          res_kind = plbs_pkg::KIND_INIT;
          res_st   = plbs_pkg::STAT_BUSY;
        end else begin
          serving_query_next = 1'b0;
          if (item.force_reset) begin
            initialized_next = 1'b0;
            cached_link_next = 5'h00;
            step_next = plbs_pkg::ST_RST_WR;
            res_fire  = 1'b1;
            res_kind  = plbs_pkg::KIND_WRITE;
            res_reg   = plbs_pkg::REG_CTRL;
            res_wval  = plbs_pkg::CTL_RESET;
          end else if (initialized) begin
            go_update = 1'b1;
          end else begin
            go_autoneg = 1'b1;
          end
        end
      end
      plbs_pkg::OP_QUERY: begin
        if (step != plbs_pkg::ST_IDLE || !(cached_link == 5'h00 || item.refresh)) begin
          res_fire  = 1'b1;
          res_kind  = plbs_pkg::KIND_LINK;
          res_flags = cached_link;
        end else begin
          serving_query_next = 1'b1;
          go_update = 1'b1;
        end
      end
      plbs_pkg::OP_XFER: begin
        case (step)
          plbs_pkg::ST_RST_WR: begin
            res_fire = 1'b1;
            if (!item.transfer_ok || reset_poll_limit == 16'd0) begin
              res_kind  = plbs_pkg::KIND_INIT;
              res_st    = plbs_pkg::STAT_HWER;
              step_next = plbs_pkg::ST_IDLE;
            end else begin
              poll_count_next   = 16'd0;
              control_copy_next = plbs_pkg::CTL_RESET;
              res_kind  = plbs_pkg::KIND_READ;
              res_reg   = plbs_pkg::REG_CTRL;
              step_next = plbs_pkg::ST_RST_RD;
            end
          end
          plbs_pkg::ST_RST_RD: begin
            if (!item.transfer_ok) begin
              res_fire  = 1'b1;
              res_kind  = plbs_pkg::KIND_INIT;
              res_st    = plbs_pkg::STAT_HWER;
              step_next = plbs_pkg::ST_IDLE;
            end else begin
              control_copy_next = item.read_value;
              if ((item.read_value & plbs_pkg::CTL_RESET) == 16'h0000) begin
                go_autoneg = 1'b1;
              end else begin
                res_fire  = 1'b1;
                res_kind  = plbs_pkg::KIND_DELAY;
                step_next = plbs_pkg::ST_RST_DLY;
              end
            end
          end
          plbs_pkg::ST_AN_RD: begin
            res_fire = 1'b1;
            if (!item.transfer_ok) begin
              res_kind  = plbs_pkg::KIND_INIT;
              res_st    = plbs_pkg::STAT_HWER;
              step_next = plbs_pkg::ST_IDLE;
            end else begin
              status_copy_next = item.read_value;
              if ((item.read_value & plbs_pkg::STA_AN_DONE) != 16'h0000) begin
                res_kind  = plbs_pkg::KIND_READ;
                res_reg   = plbs_pkg::REG_CTRL;
                step_next = plbs_pkg::ST_CTL_RD;
              end else begin
                res_kind  = plbs_pkg::KIND_DELAY;
                step_next = plbs_pkg::ST_AN_DLY;
              end
            end
          end
          plbs_pkg::ST_CTL_RD: begin
            if (!item.transfer_ok) begin
              res_fire  = 1'b1;
              res_kind  = plbs_pkg::KIND_INIT;
              res_st    = plbs_pkg::STAT_HWER;
              step_next = plbs_pkg::ST_IDLE;
            end else begin
              control_copy_next = item.read_value;
              if ((item.read_value & plbs_pkg::CTL_AN_RST) == 16'h0000) begin
                go_linkup = 1'b1;
              end else if ((status_copy & plbs_pkg::STA_100_MASK) != 16'h0000) begin
                // force 100M half duplex
                control_copy_next = (item.read_value | plbs_pkg::CTL_SPEED100)
                                    & ~plbs_pkg::CTL_FULL;
                cached_link_next = cached_link | plbs_pkg::LNK_100 | plbs_pkg::LNK_HALF;
                step_next = plbs_pkg::ST_FRC_WR;
                res_fire  = 1'b1;
                res_kind  = plbs_pkg::KIND_WRITE;
                res_reg   = plbs_pkg::REG_CTRL;
                res_wval  = control_copy_next;
              end else if ((status_copy & plbs_pkg::STA_10) != 16'h0000) begin
                control_copy_next = (item.read_value & ~plbs_pkg::CTL_SPEED100)
                                    | plbs_pkg::CTL_FULL;
                cached_link_next = cached_link | plbs_pkg::LNK_10 | plbs_pkg::LNK_HALF;
                step_next = plbs_pkg::ST_FRC_WR;
                res_fire  = 1'b1;
                res_kind  = plbs_pkg::KIND_WRITE;
                res_reg   = plbs_pkg::REG_CTRL;
                res_wval  = control_copy_next;
              end else begin
                res_fire  = 1'b1;
                res_kind  = plbs_pkg::KIND_INIT;
                res_st    = plbs_pkg::STAT_HWER;
                step_next = plbs_pkg::ST_IDLE;
              end
            end
          end
          plbs_pkg::ST_FRC_WR: begin
            go_linkup = 1'b1;
            forced    = 1'b1;
          end
          plbs_pkg::ST_LUF_RD, plbs_pkg::ST_LUA_RD: begin
            // timed-out data is still taken
            status_copy_next = item.read_value;
            forced = (step == plbs_pkg::ST_LUF_RD);
            if (!item.transfer_ok || (item.read_value & plbs_pkg::STA_LINK) != 16'h0000) begin
              go_end_linkup = 1'b1;
            end else begin
              res_fire  = 1'b1;
              res_kind  = plbs_pkg::KIND_DELAY;
              step_next = forced ? plbs_pkg::ST_LUF_DLY : plbs_pkg::ST_LUA_DLY;
            end
          end
          plbs_pkg::ST_UPD_ADV: begin
            if (!item.transfer_ok) begin
              go_end_update = 1'b1;
            end else begin
              advert_copy_next = item.read_value;
              res_fire  = 1'b1;
              res_kind  = plbs_pkg::KIND_READ;
              res_reg   = plbs_pkg::REG_LP;
              step_next = plbs_pkg::ST_UPD_LP;
            end
          end
          plbs_pkg::ST_UPD_LP: begin
            if (!item.transfer_ok) begin
              go_end_update = 1'b1;
            end else begin
              advert_copy_next = advert_copy & item.read_value;
              res_fire  = 1'b1;
              res_kind  = plbs_pkg::KIND_READ;
              res_reg   = plbs_pkg::REG_STAT;
              step_next = plbs_pkg::ST_UPD_ST;
            end
          end
          plbs_pkg::ST_UPD_ST: begin
            go_end_update = 1'b1;
            if (item.transfer_ok) begin
              upd_ok = 1'b1;
              shared = advert_copy;
              if ((shared & plbs_pkg::ADV_100) != 16'h0000) begin
                st_flags = st_flags | plbs_pkg::LNK_100;
              end else if ((shared & plbs_pkg::ADV_10) != 16'h0000) begin
                st_flags = st_flags | plbs_pkg::LNK_10;
              end
              if ((shared & plbs_pkg::ADV_FULL) != 16'h0000) begin
                st_flags = st_flags | plbs_pkg::LNK_FULL;
              end else if ((shared & plbs_pkg::ADV_HALF) != 16'h0000) begin
                st_flags = st_flags | plbs_pkg::LNK_HALF;
              end
              if ((item.read_value & plbs_pkg::STA_LINK) != 16'h0000) begin
                st_flags = st_flags | plbs_pkg::LNK_ACTIVE;
              end
              cached_link_next = st_flags;
            end
          end
          default: begin
            // stray transfer: no result
          end
        endcase
      end
      default: begin
        case (step)
          plbs_pkg::ST_RST_DLY: begin
            res_fire = 1'b1;
            if (poll_inc >= {1'b0, reset_poll_limit}) begin
              res_kind  = plbs_pkg::KIND_INIT;
              res_st    = plbs_pkg::STAT_HWER;
              step_next = plbs_pkg::ST_IDLE;
            end else begin
              poll_count_next = poll_inc[15:0];
              res_kind  = plbs_pkg::KIND_READ;
              res_reg   = plbs_pkg::REG_CTRL;
              step_next = plbs_pkg::ST_RST_RD;
            end
          end
          plbs_pkg::ST_AN_DLY: begin
            res_fire = 1'b1;
            res_kind = plbs_pkg::KIND_READ;
            if (poll_inc >= {1'b0, autoneg_poll_limit}) begin
              res_reg   = plbs_pkg::REG_CTRL;
              step_next = plbs_pkg::ST_CTL_RD;
            end else begin
              poll_count_next = poll_inc[15:0];
              res_reg   = plbs_pkg::REG_STAT;
              step_next = plbs_pkg::ST_AN_RD;
            end
          end
          plbs_pkg::ST_LUF_DLY, plbs_pkg::ST_LUA_DLY: begin
            forced = (step == plbs_pkg::ST_LUF_DLY);
            if (poll_inc >= {1'b0, linkup_poll_limit}) begin
              go_end_linkup = 1'b1;
            end else begin
              poll_count_next = poll_inc[15:0];
              res_fire  = 1'b1;
              res_kind  = plbs_pkg::KIND_READ;
              res_reg   = plbs_pkg::REG_STAT;
              step_next = forced ? plbs_pkg::ST_LUF_RD : plbs_pkg::ST_LUA_RD;
            end
          end
          default: begin
            // stray delay: no result
          end
        endcase
      end
    endcase

    // follow-on actions, in the order they chain
    if (go_autoneg) begin
      poll_count_next  = 16'd0;
      status_copy_next = 16'h0000;
      res_fire = 1'b1;
      res_kind = plbs_pkg::KIND_READ;
      if (autoneg_poll_limit == 16'd0) begin
        res_reg   = plbs_pkg::REG_CTRL;
        step_next = plbs_pkg::ST_CTL_RD;
      end else begin
        res_reg   = plbs_pkg::REG_STAT;
        step_next = plbs_pkg::ST_AN_RD;
      end
    end

    if (go_linkup) begin
      poll_count_next  = 16'd0;
      status_copy_next = 16'h0000;
      if (linkup_poll_limit == 16'd0) begin
        go_end_linkup = 1'b1;
      end else begin
        res_fire  = 1'b1;
        res_kind  = plbs_pkg::KIND_READ;
        res_reg   = plbs_pkg::REG_STAT;
        step_next = forced ? plbs_pkg::ST_LUF_RD : plbs_pkg::ST_LUA_RD;
      end
    end

    if (go_end_linkup) begin
      if (forced) begin
        if ((status_copy_next & plbs_pkg::STA_LINK) != 16'h0000) begin
          cached_link_next = cached_link_next | plbs_pkg::LNK_ACTIVE;
        end
        initialized_next = 1'b1;
        res_fire  = 1'b1;
        res_kind  = plbs_pkg::KIND_INIT;
        res_st    = plbs_pkg::STAT_OK;
        step_next = plbs_pkg::ST_IDLE;
      end else begin
        go_update = 1'b1;
      end
    end

    if (go_update) begin
      res_fire  = 1'b1;
      res_kind  = plbs_pkg::KIND_READ;
      res_reg   = plbs_pkg::REG_ADV;
      step_next = plbs_pkg::ST_UPD_ADV;
    end

    if (go_end_update) begin
      res_fire  = 1'b1;
      step_next = plbs_pkg::ST_IDLE;
      if (serving_query) begin
        serving_query_next = 1'b0;
        res_kind  = plbs_pkg::KIND_LINK;
        res_flags = cached_link_next;
      end else begin
        res_kind = plbs_pkg::KIND_INIT;
        if (initialized) begin
          res_st = plbs_pkg::STAT_OK;
        end else if (!upd_ok) begin
          res_st = plbs_pkg::STAT_HWER;
        end else begin
          initialized_next = 1'b1;
          res_st = plbs_pkg::STAT_OK;
        end
      end
    end
  end

  // fields that do not belong to the kind read as zero
  always_comb begin
    res.kind = res_kind;
    res.phy_number = (res_kind == plbs_pkg::KIND_READ || res_kind == plbs_pkg::KIND_WRITE)
                     ? phy_address : 5'd0;
    res.register_number = (res_kind == plbs_pkg::KIND_READ ||
                           res_kind == plbs_pkg::KIND_WRITE) ? res_reg : 5'd0;
    res.write_value = (res_kind == plbs_pkg::KIND_WRITE) ? res_wval : 16'h0000;
    res.init_status = (res_kind == plbs_pkg::KIND_INIT) ? res_st : plbs_pkg::STAT_OK;
    res.link_flags  = (res_kind == plbs_pkg::KIND_LINK) ? res_flags : 5'h00;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phy_address        <= 5'd1;
      reset_poll_limit   <= 16'd4000;
      autoneg_poll_limit <= 16'd16000;
      linkup_poll_limit  <= 16'd10000;
    end else if (cfg_write) begin
      case (cfg_index)
        plbs_pkg::CFG_PHY_ADDR:  phy_address        <= cfg_data[4:0];
        plbs_pkg::CFG_RST_LIMIT: reset_poll_limit   <= cfg_data;
        plbs_pkg::CFG_AN_LIMIT:  autoneg_poll_limit <= cfg_data;
        plbs_pkg::CFG_LU_LIMIT:  linkup_poll_limit  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      out_valid     <= 1'b0;
      step          <= plbs_pkg::ST_IDLE;
      poll_count    <= 16'd0;
      initialized   <= 1'b0;
      cached_link   <= 5'h00;
      control_copy  <= 16'h0000;
      status_copy   <= 16'h0000;
      advert_copy   <= 16'h0000;
      serving_query <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
      end else if (proc) begin
        item_valid <= 1'b0;
      end

      if (proc && res_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (proc) begin
        step          <= step_next;
        poll_count    <= poll_count_next;
        initialized   <= initialized_next;
        cached_link   <= cached_link_next;
        control_copy  <= control_copy_next;
        status_copy   <= status_copy_next;
        advert_copy   <= advert_copy_next;
        serving_query <= serving_query_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
    if (proc && res_fire) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_query_in_update: assert property (@(posedge clk) disable iff (rst)
    serving_query |-> (step == plbs_pkg::ST_UPD_ADV || step == plbs_pkg::ST_UPD_LP ||
                       step == plbs_pkg::ST_UPD_ST))
    else $error("query flag set outside the update sequence");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (proc && res_fire) |=> out_valid)
    else $error("resolved event produced no visible result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule
